// ===== design/mti_pkg.sv =====
// Shared types, constants and helper widths for the material table interpolator.
package mti_pkg;

   localparam int FREQ_W = 40;
   localparam int VAL_W  = 32;
   localparam int CNT_W  = 7;
   localparam int IDX_W  = 6;
   localparam int MA_W   = 35;                // multiplicand width of the shared unit
   localparam int PROD_W = MA_W + FREQ_W;     // product, dividend and quotient width
   localparam int STEP_W = $clog2(PROD_W + 1);
   localparam int ENTRY_W = FREQ_W + 5 * VAL_W;

   // eta0 * c / (2 * pi), rounded
   localparam logic [MA_W-1:0] LOSS_K = 35'd17975103585;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_ZERO_FREQ = 3'd1,
      ST_RANGE     = 3'd2,
      ST_INVALID   = 3'd3,
      ST_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_DECIDE,
      S_OP_START,
      S_OP_WAIT,
      S_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_EPS_RE,
      OP_EPS_IM,
      OP_MU_RE,
      OP_MU_IM,
      OP_COND,
      OP_LOSS
   } op_type;

   typedef enum logic [2:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV,
      MD_RND,
      MD_DONE
   } md_state_type;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef struct packed {
      logic                     kind;
      logic [IDX_W-1:0]         entry_index;
      logic [FREQ_W-1:0]        freq_hz;
      logic signed [VAL_W-1:0]  eps_re;
      logic signed [VAL_W-1:0]  eps_im;
      logic signed [VAL_W-1:0]  mu_re;
      logic signed [VAL_W-1:0]  mu_im;
      logic [VAL_W-1:0]         conductivity;
   } req_type;

   typedef struct packed {
      logic [2:0]               status;
      logic signed [VAL_W-1:0]  out_eps_re;
      logic signed [VAL_W-1:0]  out_eps_im;
      logic signed [VAL_W-1:0]  out_mu_re;
      logic signed [VAL_W-1:0]  out_mu_im;
   } rsp_type;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [VAL_W-1:0]  eps_re;
      logic [VAL_W-1:0]  eps_im;
      logic [VAL_W-1:0]  mu_re;
      logic [VAL_W-1:0]  mu_im;
      logic [VAL_W-1:0]  cond;
   } entry_type;

endpackage

// ===== design/mti_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mti_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== design/mti_muldiv.sv =====
// Bit-serial unit computing round(a * b / d), ties up: shift-add then restoring divide.
module mti_muldiv (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [mti_pkg::MA_W-1:0]   a,
   input  logic [mti_pkg::FREQ_W-1:0] b,
   input  logic [mti_pkg::FREQ_W-1:0] d,
   output logic                       done,
   output logic [mti_pkg::PROD_W-1:0] q
);
   import mti_pkg::*;

   md_state_type      state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [MA_W-1:0]   a_ff, a_in;
   logic [FREQ_W-1:0] b_ff, b_in;
   logic [FREQ_W-1:0] d_ff, d_in;
   logic [PROD_W-1:0] acc_ff, acc_in;
   logic [FREQ_W-1:0] rem_ff, rem_in;

   logic [FREQ_W:0]   psum;
   logic [FREQ_W:0]   trial;
   logic              ge;
   logic              rnd_up;

   assign psum   = {1'b0, acc_ff[PROD_W-1:MA_W]} + (a_ff[0] ? {1'b0, b_ff} : '0);
   assign trial  = {rem_ff, acc_ff[PROD_W-1]};
   assign ge     = trial >= {1'b0, d_ff};
   assign rnd_up = {rem_ff, 1'b0} >= {1'b0, d_ff};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MD_IDLE: if (start) state_in = MD_MUL;
         MD_MUL:  if (step_ff == STEP_W'(MA_W - 1)) state_in = MD_DIV;
         MD_DIV:  if (step_ff == STEP_W'(PROD_W - 1)) state_in = MD_RND;
         MD_RND:  state_in = MD_DONE;
         MD_DONE: state_in = MD_IDLE;
         default: state_in = MD_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      step_in = step_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      d_in    = d_ff;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      case (state_ff)
         MD_IDLE: begin
            if (start) begin
               a_in    = a;
               b_in    = b;
               d_in    = d;
               acc_in  = '0;
               rem_in  = '0;
               step_in = '0;
            end
         end
         MD_MUL: begin
            acc_in  = {psum, acc_ff[MA_W-1:1]};
            a_in    = a_ff >> 1;
            step_in = (step_ff == STEP_W'(MA_W - 1)) ? '0 : step_ff + 1'b1;
         end
         MD_DIV: begin
            rem_in  = ge ? FREQ_W'(trial - {1'b0, d_ff}) : trial[FREQ_W-1:0];
            acc_in  = {acc_ff[PROD_W-2:0], ge};
            step_in = step_ff + 1'b1;
         end
         MD_RND: begin
            if (rnd_up) acc_in = acc_ff + 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      d_ff    <= d_in;
      acc_ff  <= acc_in;
      rem_ff  <= rem_in;
   end

   // outputs
   always_comb begin
      done = (state_ff == MD_DONE);
      q    = acc_ff;
   end

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == MD_IDLE)
      else $error("muldiv started while busy");
   a_rem_below: assert property (@(posedge clock) disable iff (reset)
      state_ff == MD_RND |-> rem_ff < d_ff)
      else $error("remainder not below divisor");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done |=> !done)
      else $error("done held more than one cycle");
endmodule

// ===== design/material_table_interpolator_core.sv =====
// Top level of the material table interpolator: table store, scan sequencer and result stage.
//
// Usage. Request transactions arrive on req_valid/req_stall/req_data. A load
// (kind 0) writes one table entry in the cycle it is accepted and gives no
// response. A query (kind 1) scans entries 0..n-1 of the table, checking order
// and passivity and latching the bracketing pair, then runs five linear
// interpolations and the conduction-loss division on one shared bit-serial
// multiply/divide unit. Exactly one response transaction per query leaves on
// rsp_valid/rsp_stall/rsp_data.
// The length of a query is set by the serial unit (35 multiply steps and 75
// divide steps per operation) and by the read of each entry from the table RAM,
// which passes through S_SCAN_RD and then S_SCAN_CHK. A single-entry table runs
// only the loss operation; error statuses skip the arithmetic. One query is in
// work at a time.
// The register entry_count is written on csr_valid/csr_ready (always ready).
// Reset clears control state and entry_count; table contents are undefined
// until loaded. A finished response waits in the output register while the
// receiver stalls; loads and the next query are accepted meanwhile, and a
// later query holds in its last state until the output register frees.
module material_table_interpolator_core #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  mti_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output mti_pkg::rsp_type          rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [mti_pkg::CNT_W-1:0] csr_data
);
   import mti_pkg::*;

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int NW = $clog2(TABLE_DEPTH + 1);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff;
   logic [NW-1:0]     n_ff;
   logic [NW-1:0]     idx_ff;
   logic [FREQ_W-1:0] f_ff;
   entry_type         prev_ff, lo_ff, hi_ff;
   logic              found_ff, bad_ff, range_ff;
   logic [2:0]        status_ff;
   op_type            op_ff;
   logic [FREQ_W-1:0] num_ff, den_ff;
   logic [VAL_W-1:0]  res_ff [4];
   logic [VAL_W-1:0]  sg_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic              req_fire;
   logic              finish_fire;
   logic              last_entry;
   entry_type         cur;
   entry_type         wr_entry;
   logic              wr_en;
   logic [NW-1:0]     n_clamped;

   logic              md_start, md_done;
   logic [MA_W-1:0]   md_a;
   logic [FREQ_W-1:0] md_b, md_d;
   logic [PROD_W-1:0] md_q;

   logic [VAL_W:0]    lo_v, up_v;
   logic [VAL_W+1:0]  diff;
   logic              neg;
   logic [VAL_W:0]    mag;
   logic [VAL_W+1:0]  lerp_res;
   logic [VAL_W:0]    loss;
   logic [VAL_W+1:0]  ei_sum;
   logic [VAL_W-1:0]  ei_sat;

   function automatic logic positive(input logic [VAL_W-1:0] v);
      return !v[VAL_W-1] && (v != '0);
   endfunction

   // Table store: one wide entry per slot
   assign wr_entry = '{freq: req_data.freq_hz, eps_re: req_data.eps_re,
                       eps_im: req_data.eps_im, mu_re: req_data.mu_re,
                       mu_im: req_data.mu_im, cond: req_data.conductivity};
   assign wr_en = req_fire && (req_data.kind == KIND_LOAD)
                  && (int'(req_data.entry_index) < TABLE_DEPTH);

   mti_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (AW'(req_data.entry_index)),
      .wr_data (wr_entry),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (cur)
   );

   mti_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .start (md_start),
      .a     (md_a),
      .b     (md_b),
      .d     (md_d),
      .done  (md_done),
      .q     (md_q)
   );

   assign n_clamped  = (int'(count_ff) > TABLE_DEPTH) ? NW'(TABLE_DEPTH) : NW'(count_ff);
   assign last_entry = (idx_ff == n_ff - 1'b1);

   // Operand selection for the current operation
   always_comb begin
      case (op_ff)
         OP_EPS_RE: begin
            lo_v = {lo_ff.eps_re[VAL_W-1], lo_ff.eps_re};
            up_v = {hi_ff.eps_re[VAL_W-1], hi_ff.eps_re};
         end
         OP_EPS_IM: begin
            lo_v = {lo_ff.eps_im[VAL_W-1], lo_ff.eps_im};
            up_v = {hi_ff.eps_im[VAL_W-1], hi_ff.eps_im};
         end
         OP_MU_RE: begin
            lo_v = {lo_ff.mu_re[VAL_W-1], lo_ff.mu_re};
            up_v = {hi_ff.mu_re[VAL_W-1], hi_ff.mu_re};
         end
         OP_MU_IM: begin
            lo_v = {lo_ff.mu_im[VAL_W-1], lo_ff.mu_im};
            up_v = {hi_ff.mu_im[VAL_W-1], hi_ff.mu_im};
         end
         OP_COND: begin
            lo_v = {1'b0, lo_ff.cond};
            up_v = {1'b0, hi_ff.cond};
         end
         default: begin
            lo_v = '0;
            up_v = '0;
         end
      endcase
   end

   assign diff = {up_v[VAL_W], up_v} - {lo_v[VAL_W], lo_v};
   assign neg  = diff[VAL_W+1];
   assign mag  = neg ? (VAL_W+1)'(-diff) : diff[VAL_W:0];

   assign md_a = (op_ff == OP_LOSS) ? LOSS_K : MA_W'(mag);
   assign md_b = (op_ff == OP_LOSS) ? FREQ_W'(sg_ff) : num_ff;
   assign md_d = (op_ff == OP_LOSS) ? f_ff : den_ff;

   // lo +/- rounded quotient; quotient never exceeds the magnitude
   assign lerp_res = neg ? {lo_v[VAL_W], lo_v} - md_q[VAL_W+1:0]
                         : {lo_v[VAL_W], lo_v} + md_q[VAL_W+1:0];

   // Conduction loss, saturated at 2^31, then subtract with floor saturation
   always_comb begin
      if ((md_q[PROD_W-1:VAL_W] != '0) || (md_q[VAL_W-1:0] > {1'b1, {(VAL_W-1){1'b0}}})) begin
         loss = {2'b01, {(VAL_W-1){1'b0}}};
      end else begin
         loss = {1'b0, md_q[VAL_W-1:0]};
      end
      ei_sum = {{2{res_ff[1][VAL_W-1]}}, res_ff[1]} - {1'b0, loss};
      if (ei_sum[VAL_W+1] && (ei_sum[VAL_W:VAL_W-1] != 2'b11)) begin
         ei_sat = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         ei_sat = ei_sum[VAL_W-1:0];
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && req_data.kind == KIND_QUERY) begin
               state_in = (n_clamped == '0) ? S_DECIDE : S_SCAN_RD;
            end
         end
         S_SCAN_RD:  state_in = S_SCAN_CHK;
         S_SCAN_CHK: state_in = last_entry ? S_DECIDE : S_SCAN_RD;
         S_DECIDE: begin
            if (bad_ff || f_ff == '0 || n_ff == '0 || (n_ff != NW'(1) && range_ff)) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_OP_START;
            end
         end
         S_OP_START: state_in = S_OP_WAIT;
         S_OP_WAIT: begin
            if (md_done) state_in = (op_ff == OP_LOSS) ? S_FINISH : S_OP_START;
         end
         S_FINISH: if (finish_fire) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      req_stall   = (state_ff != S_IDLE);
      req_fire    = req_valid && !req_stall;
      md_start    = (state_ff == S_OP_START);
      finish_fire = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);
      csr_ready   = 1'b1;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) begin
            count_ff <= csr_data;
         end
         if (finish_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               f_ff     <= req_data.freq_hz;
               n_ff     <= n_clamped;
               idx_ff   <= '0;
               found_ff <= 1'b0;
               bad_ff   <= 1'b0;
               range_ff <= 1'b0;
            end
         end
         S_SCAN_CHK: begin
            // check order and passivity of this entry
            if (cur.freq == '0 || (idx_ff != '0 && cur.freq <= prev_ff.freq)
                || positive(cur.eps_im) || positive(cur.mu_im)) begin
               bad_ff <= 1'b1;
            end
            if ((idx_ff == '0 && f_ff < cur.freq) || (last_entry && f_ff > cur.freq)) begin
               range_ff <= 1'b1;
            end
            // latch the first upper bracket at or above the query past entry 0, else the last or only entry
            if (!found_ff && ((idx_ff != '0 && (cur.freq >= f_ff || last_entry))
                              || n_ff == NW'(1))) begin
               hi_ff    <= cur;
               lo_ff    <= prev_ff;
               found_ff <= 1'b1;
            end
            prev_ff <= cur;
            idx_ff  <= idx_ff + 1'b1;
         end
         S_DECIDE: begin
            if (bad_ff) begin
               status_ff <= ST_INVALID;
            end else if (f_ff == '0) begin
               status_ff <= ST_ZERO_FREQ;
            end else if (n_ff == '0) begin
               status_ff <= ST_EMPTY;
            end else if (n_ff != NW'(1) && range_ff) begin
               status_ff <= ST_RANGE;
            end else begin
               status_ff <= ST_OK;
            end
            num_ff <= f_ff - lo_ff.freq;
            den_ff <= hi_ff.freq - lo_ff.freq;
            if (n_ff == NW'(1)) begin
               // single entry: take it as is, only the loss remains
               res_ff[0] <= hi_ff.eps_re;
               res_ff[1] <= hi_ff.eps_im;
               res_ff[2] <= hi_ff.mu_re;
               res_ff[3] <= hi_ff.mu_im;
               sg_ff     <= hi_ff.cond;
               op_ff     <= OP_LOSS;
            end else begin
               op_ff <= OP_EPS_RE;
            end
         end
         S_OP_WAIT: begin
            if (md_done) begin
               case (op_ff)
                  OP_EPS_RE: begin
                     res_ff[0] <= lerp_res[VAL_W-1:0];
                     op_ff     <= OP_EPS_IM;
                  end
                  OP_EPS_IM: begin
                     res_ff[1] <= lerp_res[VAL_W-1:0];
                     op_ff     <= OP_MU_RE;
                  end
                  OP_MU_RE: begin
                     res_ff[2] <= lerp_res[VAL_W-1:0];
                     op_ff     <= OP_MU_IM;
                  end
                  OP_MU_IM: begin
                     res_ff[3] <= lerp_res[VAL_W-1:0];
                     op_ff     <= OP_COND;
                  end
                  OP_COND: begin
                     sg_ff <= lerp_res[VAL_W-1:0];
                     op_ff <= OP_LOSS;
                  end
                  default: begin
                     res_ff[1] <= ei_sat;
                  end
               endcase
            end
         end
         default: ;
      endcase
      // load the output register; error statuses carry zero values
      if (finish_fire) begin
         rsp_data_ff.status <= status_ff;
         if (status_ff == ST_OK) begin
            rsp_data_ff.out_eps_re <= res_ff[0];
            rsp_data_ff.out_eps_im <= res_ff[1];
            rsp_data_ff.out_mu_re  <= res_ff[2];
            rsp_data_ff.out_mu_im  <= res_ff[3];
         end else begin
            rsp_data_ff.out_eps_re <= '0;
            rsp_data_ff.out_eps_im <= '0;
            rsp_data_ff.out_mu_re  <= '0;
            rsp_data_ff.out_mu_im  <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_done_waited: assert property (@(posedge clock) disable iff (reset)
      md_done |-> state_ff == S_OP_WAIT)
      else $error("arithmetic result arrived outside the wait state");
   a_finish_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("finished query not presented");
   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |->
      (rsp_data.out_eps_re == '0 && rsp_data.out_eps_im == '0
       && rsp_data.out_mu_re == '0 && rsp_data.out_mu_im == '0))
      else $error("error response carries nonzero values");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN_CHK |-> idx_ff < n_ff)
      else $error("scan ran past the entries in use");
endmodule
